>>> sv/tcp_syn_backlog_queue_defines.svh
// Assertion macros shared by the backlog queue RTL.
`ifndef TCP_SYN_BACKLOG_QUEUE_DEFINES_SVH
`define TCP_SYN_BACKLOG_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TSBQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tsbq assertion failed");
`define TSBQ_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("tsbq assertion failed");
`else
`define TSBQ_ASSERT(name, clk, rst, prop)
`define TSBQ_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> sv/tsbq_pkg.sv
package tsbq_pkg;

   localparam logic [1:0] OP_OFFER = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam int SYN_BIT = 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  tcp_flags;
      logic [15:0] source_port;
      logic [31:0] source_address;
      logic [31:0] sequence_number;
      logic [15:0] max_segment_size;
      logic [2:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        stored;
      logic        found;
      logic [2:0]  found_slot;
      logic [15:0] entry_port;
      logic [31:0] entry_address;
      logic [31:0] entry_next_sequence;
      logic [15:0] entry_mss;
   } rsp_type;

   typedef struct packed {
      logic [15:0] port;
      logic [31:0] address;
      logic [31:0] next_sequence;
      logic [15:0] mss;
   } slot_entry_type;

endpackage

>>> sv/tsbq_ram.sv
module tsbq_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tcp_syn_backlog_queue.sv
// Offer, free and no-op words: result in the cycle after start, next start the cycle after.
// Find: the ring is scanned one slot per cycle, then on a hit the slot RAM gives its
// registered read. Results are single-cycle strobes on rsp_valid.
// Reset (synchronous) frees every slot and zeroes the write pointer.
`include "tcp_syn_backlog_queue_defines.svh"

module tcp_syn_backlog_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tsbq_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_valid,
   output tsbq_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   tsbq_pkg::state_type      state_ff, state_in;
   logic [IDX_W-1:0]         wp_ff, wp_in;
   logic [IDX_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [QUEUE_DEPTH-1:0]   occupied_ff, occupied_in;
   tsbq_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     wr_en;
   tsbq_pkg::slot_entry_type wr_data;
   logic                     rd_en;
   tsbq_pkg::slot_entry_type rd_data;
   logic                     offer_ok;
   logic                     free_ok;
   logic [IDX_W-1:0]         free_idx;

   tsbq_ram #(
      .WIDTH($bits(tsbq_pkg::slot_entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ptr_ff),
      .rd_data (rd_data)
   );

   assign offer_ok = req_item.tcp_flags[tsbq_pkg::SYN_BIT] && (req_item.source_port != '0);
   assign free_ok  = int'(req_item.slot_index) < QUEUE_DEPTH;
   assign free_idx = IDX_W'(req_item.slot_index);

   always_comb begin
      wr_data.port          = req_item.source_port;
      wr_data.address       = req_item.source_address;
      wr_data.next_sequence = req_item.sequence_number + 32'd1;
      wr_data.mss           = req_item.max_segment_size;
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      scan_ptr_in  = scan_ptr_ff;
      cnt_in       = cnt_ff;
      occupied_in  = occupied_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         tsbq_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_item.opcode)
                  tsbq_pkg::OP_OFFER: begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.accepted = offer_ok;
                     if (offer_ok && !occupied_ff[wp_ff]) begin
                        wr_en              = 1'b1;
                        occupied_in[wp_ff] = 1'b1;
                        wp_in              = ring_next(wp_ff);
                        rsp_in.stored      = 1'b1;
                     end
                  end
                  tsbq_pkg::OP_FIND: begin
                     scan_ptr_in = ring_next(wp_ff);
                     cnt_in      = '0;
                     state_in    = tsbq_pkg::ST_SCAN;
                  end
                  tsbq_pkg::OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (free_ok) begin
                        occupied_in[free_idx] = 1'b0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         tsbq_pkg::ST_SCAN: begin
            if (occupied_ff[scan_ptr_ff]) begin
               rd_en    = 1'b1;
               state_in = tsbq_pkg::ST_READ;
            end else if (cnt_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = tsbq_pkg::ST_IDLE;
            end else begin
               scan_ptr_in = ring_next(scan_ptr_ff);
               cnt_in      = cnt_ff + 1'b1;
            end
         end
         tsbq_pkg::ST_READ: begin
            rsp_valid_in               = 1'b1;
            rsp_in.found               = 1'b1;
            rsp_in.found_slot          = 3'(scan_ptr_ff);
            rsp_in.entry_port          = rd_data.port;
            rsp_in.entry_address       = rd_data.address;
            rsp_in.entry_next_sequence = rd_data.next_sequence;
            rsp_in.entry_mss           = rd_data.mss;
            state_in                   = tsbq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tsbq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsbq_pkg::ST_IDLE;
         wp_ff        <= '0;
         occupied_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         occupied_ff  <= occupied_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != tsbq_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `TSBQ_ASSERT(a_start_leads_on, clock, reset, start && !busy |=> rsp_valid || busy)
   `TSBQ_ASSERT(a_no_rsp_while_busy, clock, reset, busy |-> !rsp_valid)
   `TSBQ_ASSERT(a_read_slot_held, clock, reset, (state_ff == tsbq_pkg::ST_READ) |-> occupied_ff[scan_ptr_ff])
   `TSBQ_ASSERT(a_stored_accepted, clock, reset, rsp_valid && rsp_item.stored |-> rsp_item.accepted)
   `TSBQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid)

endmodule

>>> tb/tsbq_checker.sv
`timescale 1ns / 1ps

module tsbq_checker #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  tsbq_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  tsbq_pkg::rsp_type rsp_item,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count,
   output int                stored_count,
   output int                found_count
);

   logic [15:0]       backlog_port     [QUEUE_DEPTH];
   logic [31:0]       backlog_address  [QUEUE_DEPTH];
   logic [31:0]       backlog_next_seq [QUEUE_DEPTH];
   logic [15:0]       backlog_mss      [QUEUE_DEPTH];
   int                backlog_wr_ptr;
   tsbq_pkg::rsp_type pending_replies [$];

   function automatic tsbq_pkg::rsp_type apply_to_backlog(input tsbq_pkg::req_type w);
      tsbq_pkg::rsp_type r;
      int                slot;
      r = '0;
      case (w.opcode)
         tsbq_pkg::OP_OFFER: begin
            if (w.tcp_flags[tsbq_pkg::SYN_BIT] && w.source_port != 16'd0) begin
               r.accepted = 1'b1;
               slot = backlog_wr_ptr;
               if (backlog_port[slot] == 16'd0) begin
                  backlog_port[slot] = w.source_port;
                  backlog_address[slot] = w.source_address;
                  backlog_next_seq[slot] = w.sequence_number + 32'd1;
                  backlog_mss[slot] = w.max_segment_size;
                  backlog_wr_ptr = (slot + 1) % QUEUE_DEPTH;
                  r.stored = 1'b1;
               end
            end
         end
         tsbq_pkg::OP_FIND: begin
            slot = backlog_wr_ptr;
            for (int n = 0; n < QUEUE_DEPTH; n++) begin
               slot = (slot + 1) % QUEUE_DEPTH;
               if (backlog_port[slot] != 16'd0) begin
                  r.found = 1'b1;
                  r.found_slot = slot[2:0];
                  r.entry_port = backlog_port[slot];
                  r.entry_address = backlog_address[slot];
                  r.entry_next_sequence = backlog_next_seq[slot];
                  r.entry_mss = backlog_mss[slot];
                  break;
               end
            end
         end
         tsbq_pkg::OP_FREE: begin
            if (int'(w.slot_index) < QUEUE_DEPTH) begin
               backlog_port[w.slot_index] = 16'd0;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      tsbq_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            backlog_port[i] = '0;
            backlog_address[i] = '0;
            backlog_next_seq[i] = '0;
            backlog_mss[i] = '0;
         end
         backlog_wr_ptr = 0;
         pending_replies.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_replies.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_item);
            end else begin
               want = pending_replies.pop_front();
               check_field("accepted", want.accepted, rsp_item.accepted);
               check_field("stored", want.stored, rsp_item.stored);
               check_field("found", want.found, rsp_item.found);
               check_field("found_slot", want.found_slot, rsp_item.found_slot);
               check_field("entry_port", want.entry_port, rsp_item.entry_port);
               check_field("entry_address", want.entry_address, rsp_item.entry_address);
               check_field("entry_next_sequence", want.entry_next_sequence,
                           rsp_item.entry_next_sequence);
               check_field("entry_mss", want.entry_mss, rsp_item.entry_mss);
               checked_count++;
            end
         end
         if (start && !busy) begin
            want = apply_to_backlog(req_item);
            if (want.stored) stored_count++;
            if (want.found) found_count++;
            pending_replies.push_back(want);
         end
      end
      pending_count = pending_replies.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int         QUEUE_DEPTH = 8;
   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int         RANDOM_WORDS = 550;
   localparam int         SETTLE_CYCLES = QUEUE_DEPTH + 4;
   localparam int         DRAIN_LIMIT = 1000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              rsp_valid;
   tsbq_pkg::req_type req_item;
   tsbq_pkg::rsp_type rsp_item;
   int                fail_count;
   int                pending_count;
   int                checked_count;
   int                stored_count;
   int                found_count;
   int                sent_by_op [4];
   int                idle_pct;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   tcp_syn_backlog_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   tsbq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .stored_count (stored_count),
      .found_count  (found_count)
   );

   function automatic tsbq_pkg::req_type offer_word(input logic [7:0] flags,
                                                    input logic [15:0] port,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] seq,
                                                    input logic [15:0] mss);
      tsbq_pkg::req_type w;
      w = '0;
      w.opcode = tsbq_pkg::OP_OFFER;
      w.tcp_flags = flags;
      w.source_port = port;
      w.source_address = addr;
      w.sequence_number = seq;
      w.max_segment_size = mss;
      return w;
   endfunction

   function automatic tsbq_pkg::req_type control_word(input logic [1:0] op,
                                                      input logic [2:0] slot);
      tsbq_pkg::req_type w;
      w = '0;
      w.opcode = op;
      w.slot_index = slot;
      return w;
   endfunction

   function automatic tsbq_pkg::req_type random_word();
      tsbq_pkg::req_type w;
      int                pick;
      w.tcp_flags = 8'($urandom_range(255));
      w.source_port = 16'($urandom_range(65535));
      w.source_address = $urandom;
      w.sequence_number = $urandom;
      w.max_segment_size = 16'($urandom_range(65535));
      w.slot_index = 3'($urandom_range(7));
      pick = int'($urandom_range(99));
      if (pick < 45) begin
         w.opcode = tsbq_pkg::OP_OFFER;
         if ($urandom_range(9) != 0) begin
            w.tcp_flags[tsbq_pkg::SYN_BIT] = 1'b1;
            if (w.source_port == 16'd0) w.source_port = 16'd1;
         end else if ($urandom_range(1) == 1) begin
            w.source_port = '0;
         end
         if ($urandom_range(7) == 0) w.max_segment_size = '0;
         if ($urandom_range(15) == 0) w.sequence_number = '1;
      end else if (pick < 65) begin
         w.opcode = tsbq_pkg::OP_FIND;
      end else if (pick < 93) begin
         w.opcode = tsbq_pkg::OP_FREE;
      end else begin
         w.opcode = OP_NOP;
      end
      return w;
   endfunction

   task automatic send_word(input tsbq_pkg::req_type w);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_item <= w;
      do @(posedge clock); while (busy);
      sent_by_op[w.opcode]++;
      @(negedge clock);
   endtask

   initial begin
      int phase_idle [4];
      int waited;
      phase_idle = '{0, 72, 0, 31};
      idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(control_word(tsbq_pkg::OP_FIND, 3'd0));
      send_word(offer_word(8'h02, 16'h0000, $urandom, $urandom, 16'd1460));
      send_word(offer_word(8'hFD, 16'hFFFF, $urandom, $urandom, 16'd536));
      send_word(offer_word(8'h02, 16'h0001, 32'h0, 32'h0, 16'h0));
      send_word(offer_word(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_word(control_word(tsbq_pkg::OP_FIND, 3'd7));
      for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
         send_word(offer_word(8'h12, 16'(1024 + i), $urandom, $urandom, 16'(1200 + i)));
      end
      send_word(offer_word(8'h02, 16'd4242, $urandom, $urandom, 16'd9000));
      send_word(control_word(tsbq_pkg::OP_FIND, 3'd0));
      send_word(control_word(tsbq_pkg::OP_FREE, 3'd0));
      send_word(offer_word(8'h02, 16'd8080, $urandom, $urandom, 16'd1440));
      send_word(control_word(OP_NOP, 3'd5));
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_word(control_word(tsbq_pkg::OP_FREE, 3'(i)));
      end
      send_word(control_word(tsbq_pkg::OP_FREE, 3'd7));
      send_word(control_word(tsbq_pkg::OP_FIND, 3'd0));

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         repeat (RANDOM_WORDS / 4) send_word(random_word());
      end
      start <= 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_count != 0) begin
         $display("%0t: %0d result words never arrived", $time, pending_count);
      end

      $display("Sent %0d offers, %0d finds, %0d frees and %0d no-op words under four idle mixes.",
               sent_by_op[tsbq_pkg::OP_OFFER], sent_by_op[tsbq_pkg::OP_FIND],
               sent_by_op[tsbq_pkg::OP_FREE], sent_by_op[OP_NOP]);
      $display("Checked %0d result words; %0d offers were stored and %0d finds hit an entry.",
               checked_count, stored_count, found_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tcp_syn_backlog_queue test passed");
      end else begin
         $display("tcp_syn_backlog_queue test failed");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tcp_syn_backlog_queue test failed");
      $finish;
   end

endmodule
